// ----- hw/rtl/lcbs_pkg.sv -----
// Shared types and constants for the link connect backoff supervisor.
package lcbs_pkg;

	localparam int TIME_W    = 32;
	localparam int STATUS_W  = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [TIME_W-1:0] RST_CHECK_INTERVAL   = 32'd500;
	localparam logic [TIME_W-1:0] RST_RETRY_INTERVAL   = 32'd5000;
	localparam logic [TIME_W-1:0] RST_INITIAL_BACKOFF  = 32'd60000;
	localparam logic [TIME_W-1:0] RST_MAXIMUM_BACKOFF  = 32'd600000;
	localparam logic [TIME_W-1:0] RST_CONNECT_TIMEOUT  = 32'd60000;
	localparam logic [TIME_W-1:0] RST_RESTORED_BACKOFF = 32'd0;
	localparam logic [TIME_W-1:0] POLL_NEVER           = '1;

	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE         = 4'd0,
		ST_NO_NET       = 4'd1,
		ST_SCAN_DONE    = 4'd2,
		ST_CONNECTED    = 4'd3,
		ST_FAILED       = 4'd4,
		ST_LOST         = 4'd5,
		ST_BAD_KEY      = 4'd6,
		ST_DISCONNECTED = 4'd7,
		ST_NO_DEVICE    = 4'd8
	} link_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_INTERVAL   = 3'd0,
		CFG_RETRY_INTERVAL   = 3'd1,
		CFG_INITIAL_BACKOFF  = 3'd2,
		CFG_MAXIMUM_BACKOFF  = 3'd3,
		CFG_CONNECT_TIMEOUT  = 3'd4,
		CFG_RESTORED_BACKOFF = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] check_interval;
		logic [TIME_W-1:0] retry_interval;
		logic [TIME_W-1:0] initial_backoff;
		logic [TIME_W-1:0] maximum_backoff;
		logic [TIME_W-1:0] connect_timeout;
		logic [TIME_W-1:0] restored_backoff;
	} cfg_regs_t;

	typedef struct packed {
		logic              load;
		logic [TIME_W-1:0] value;
	} backoff_load_t;

	typedef struct packed {
		logic              link_up;
		logic              start_attempt;
		logic              reboot_request;
		logic              backoff_write;
		logic [TIME_W-1:0] backoff_value;
	} result_t;

endpackage

// ----- hw/rtl/lcbs_poll_if.sv -----
// Poll channel: timestamp and link status.
interface lcbs_poll_if;
	import lcbs_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   now_ms;
	logic [STATUS_W-1:0] link_status;

	modport source (output valid, output now_ms, output link_status, input ready);
	modport sink (input valid, input now_ms, input link_status, output ready);
endinterface

// ----- hw/rtl/lcbs_result_if.sv -----
// Result channel: link and backoff reports.
interface lcbs_result_if;
	import lcbs_pkg::*;

	logic              valid;
	logic              ready;
	logic              link_up;
	logic              start_attempt;
	logic              reboot_request;
	logic              backoff_write;
	logic [TIME_W-1:0] backoff_value;

	modport source (output valid, output link_up, output start_attempt,
		output reboot_request, output backoff_write, output backoff_value, input ready);
	modport sink (input valid, input link_up, input start_attempt,
		input reboot_request, input backoff_write, input backoff_value, output ready);
endinterface

// ----- hw/rtl/lcbs_cfg_if.sv -----
// Configuration write channel.
interface lcbs_cfg_if;
	import lcbs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIME_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lcbs_cfg_regs.sv -----
// Configuration register file and backoff reload on restore writes.
module lcbs_cfg_regs
	import lcbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [TIME_W-1:0]    wr_data,
	output cfg_regs_t            regs,
	output backoff_load_t        bload
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.check_interval   <= RST_CHECK_INTERVAL;
			regs_q.retry_interval   <= RST_RETRY_INTERVAL;
			regs_q.initial_backoff  <= RST_INITIAL_BACKOFF;
			regs_q.maximum_backoff  <= RST_MAXIMUM_BACKOFF;
			regs_q.connect_timeout  <= RST_CONNECT_TIMEOUT;
			regs_q.restored_backoff <= RST_RESTORED_BACKOFF;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CHECK_INTERVAL:   regs_q.check_interval   <= wr_data;
				CFG_RETRY_INTERVAL:   regs_q.retry_interval   <= wr_data;
				CFG_INITIAL_BACKOFF:  regs_q.initial_backoff  <= wr_data;
				CFG_MAXIMUM_BACKOFF:  regs_q.maximum_backoff  <= wr_data;
				CFG_CONNECT_TIMEOUT:  regs_q.connect_timeout  <= wr_data;
				CFG_RESTORED_BACKOFF: regs_q.restored_backoff <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

	// reload the backoff window as a start-up would
	always_comb begin
		bload.load  = wr_en && (wr_index == CFG_RESTORED_BACKOFF);
		bload.value = (wr_data != '0) ? wr_data : regs_q.initial_backoff;
	end

endmodule

// ----- hw/rtl/lcbs_core.sv -----
// Supervisor state registers and per-poll next-state and result logic.
module lcbs_core
	import lcbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic [STATUS_W-1:0] link_status,
	input  cfg_regs_t           cfg,
	input  backoff_load_t       bload,
	output result_t             res
);

	logic [TIME_W-1:0] next_poll_q, next_poll_d;
	logic              active_q, active_d;
	logic [TIME_W-1:0] start_time_q, start_time_d;
	logic [TIME_W-1:0] last_fail_q, last_fail_d;
	logic [TIME_W-1:0] backoff_q, backoff_d;
	logic              fail;
	logic [TIME_W:0]   dbl;
	logic [TIME_W-1:0] grown;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_poll_q  <= '0;
			active_q     <= 1'b0;
			start_time_q <= '0;
			last_fail_q  <= '0;
			backoff_q    <= RST_INITIAL_BACKOFF;
		end else begin
			if (upd) begin
				next_poll_q  <= next_poll_d;
				active_q     <= active_d;
				start_time_q <= start_time_d;
				last_fail_q  <= last_fail_d;
				backoff_q    <= backoff_d;
			end
			if (bload.load) begin
				backoff_q <= bload.value;
			end
		end
	end

	assign dbl   = {backoff_q, 1'b0};
	assign grown = (dbl < {1'b0, cfg.maximum_backoff}) ? dbl[TIME_W-1:0] : cfg.maximum_backoff;

	always_comb begin
		next_poll_d  = next_poll_q;
		active_d     = active_q;
		start_time_d = start_time_q;
		last_fail_d  = last_fail_q;
		backoff_d    = backoff_q;
		fail         = 1'b0;
		res          = '0;

		if (link_status == ST_CONNECTED) begin
			res.link_up = 1'b1;
			if (active_q) begin
				active_d          = 1'b0;
				backoff_d         = cfg.initial_backoff;
				res.backoff_write = 1'b1;
				res.backoff_value = cfg.initial_backoff;
				last_fail_d       = '0;
			end
		end else if (now_ms >= next_poll_q) begin
			if (!active_q) begin
				active_d          = 1'b1;
				next_poll_d       = now_ms;
				start_time_d      = now_ms;
				res.start_attempt = 1'b1;
			end else begin
				case (link_status)
					ST_NO_DEVICE: begin
						next_poll_d = POLL_NEVER;
					end
					ST_IDLE, ST_DISCONNECTED: begin
						if (start_time_q < (now_ms - cfg.connect_timeout)) begin
							fail = 1'b1;
						end else begin
							next_poll_d = next_poll_q + cfg.check_interval;
						end
					end
					ST_FAILED, ST_NO_NET: begin
						fail = 1'b1;
					end
					default: begin
						active_d    = 1'b0;
						next_poll_d = next_poll_q + cfg.retry_interval;
					end
				endcase
				if (fail) begin
					if ((last_fail_q != '0) && (last_fail_q < (now_ms - backoff_q))) begin
						backoff_d          = grown;
						res.reboot_request = 1'b1;
						res.backoff_write  = 1'b1;
						res.backoff_value  = grown;
					end
					last_fail_d = now_ms;
					active_d    = 1'b0;
					next_poll_d = next_poll_q + cfg.retry_interval;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/link_connect_backoff_supervisor.sv -----
// Top level: poll input register, supervisor core and result register.
// A poll is held in the poll input register, and its result in the result register.
// Throughput: one poll per cycle while results are taken; the state update
// of one poll is a single compare/add stage between the input register and the result register.
// Reset: clears the valid bits of both stages and the state; backoff window starts at 60000,
// registers take their default values.
module link_connect_backoff_supervisor
	import lcbs_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	lcbs_poll_if.sink     poll,
	lcbs_result_if.source result,
	lcbs_cfg_if.sink      cfg
);

	logic                valid_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [STATUS_W-1:0] status_s1;
	logic                res_valid_q;
	result_t             res_q;
	result_t             res_d;
	logic                advance;
	logic                upd;
	cfg_regs_t           regs;
	backoff_load_t       bload;

	assign advance    = !res_valid_q || result.ready;
	assign upd        = valid_s1 && advance;
	assign poll.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			now_s1    <= poll.now_ms;
			status_s1 <= poll.link_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			res_q <= res_d;
		end
	end

	lcbs_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs),
		.bload    (bload)
	);

	lcbs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.now_ms      (now_s1),
		.link_status (status_s1),
		.cfg         (regs),
		.bload       (bload),
		.res         (res_d)
	);

	assign result.valid          = res_valid_q;
	assign result.link_up        = res_q.link_up;
	assign result.start_attempt  = res_q.start_attempt;
	assign result.reboot_request = res_q.reboot_request;
	assign result.backoff_write  = res_q.backoff_write;
	assign result.backoff_value  = res_q.backoff_value;

endmodule

// ----- test/tb.sv -----
// Testbench for link_connect_backoff_supervisor: directed and random polls against a backoff predictor.
import lcbs_pkg::*;

class backoff_tracker;
	logic [TIME_W-1:0] check_iv, retry_iv, init_bo, max_bo, conn_to, saved_bo;
	logic [TIME_W-1:0] poll_due, start_ms, fail_ms, window;
	bit                attempt_on;
	result_t           expected_reports[$];
	int                mismatches, attempts, ups, reboots, bo_writes;

	function void power_on();
		check_iv   = RST_CHECK_INTERVAL;
		retry_iv   = RST_RETRY_INTERVAL;
		init_bo    = RST_INITIAL_BACKOFF;
		max_bo     = RST_MAXIMUM_BACKOFF;
		conn_to    = RST_CONNECT_TIMEOUT;
		saved_bo   = RST_RESTORED_BACKOFF;
		poll_due   = '0;
		start_ms   = '0;
		fail_ms    = '0;
		attempt_on = 1'b0;
		window     = (saved_bo != 0) ? saved_bo : init_bo;
	endfunction

	function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
		case (idx)
			CFG_CHECK_INTERVAL:  check_iv = val;
			CFG_RETRY_INTERVAL:  retry_iv = val;
			CFG_INITIAL_BACKOFF: init_bo = val;
			CFG_MAXIMUM_BACKOFF: max_bo = val;
			CFG_CONNECT_TIMEOUT: conn_to = val;
			CFG_RESTORED_BACKOFF: begin
				saved_bo = val;
				window = (val != 0) ? val : init_bo;
			end
			default: ;
		endcase
	endfunction

	function void note_poll(logic [TIME_W-1:0] now, logic [STATUS_W-1:0] st);
		result_t         r;
		bit              fails;
		logic [TIME_W:0] dbl;
		r = '0;
		fails = 1'b0;
		if (st == ST_CONNECTED) begin
			r.link_up = 1'b1;
			if (attempt_on) begin
				attempt_on = 1'b0;
				window = init_bo;
				r.backoff_write = 1'b1;
				r.backoff_value = window;
				fail_ms = '0;
			end
		end else if (now >= poll_due) begin
			if (!attempt_on) begin
				attempt_on = 1'b1;
				poll_due = now;
				start_ms = now;
				r.start_attempt = 1'b1;
			end else begin
				case (st)
					ST_NO_DEVICE: poll_due = POLL_NEVER;
					ST_IDLE, ST_DISCONNECTED: begin
						if (start_ms < now - conn_to)
							fails = 1'b1;
						else
							poll_due = poll_due + check_iv;
					end
					ST_FAILED, ST_NO_NET: fails = 1'b1;
					default: begin
						attempt_on = 1'b0;
						poll_due = poll_due + retry_iv;
					end
				endcase
			end
			if (fails) begin
				if (fail_ms != 0 && fail_ms < now - window) begin
					dbl = {window, 1'b0};
					window = (dbl < {1'b0, max_bo}) ? dbl[TIME_W-1:0] : max_bo;
					r.reboot_request = 1'b1;
					r.backoff_write = 1'b1;
					r.backoff_value = window;
				end
				fail_ms = now;
				attempt_on = 1'b0;
				poll_due = poll_due + retry_iv;
			end
		end
		attempts += r.start_attempt;
		ups += r.link_up;
		reboots += r.reboot_request;
		bo_writes += r.backoff_write;
		expected_reports.push_back(r);
	endfunction

	function void check_report(result_t got);
		result_t exp;
		if (expected_reports.size() == 0) begin
			$display("%0t: report with nothing expected: %h", $time, got);
			mismatches++;
			return;
		end
		exp = expected_reports.pop_front();
		if (got.link_up !== exp.link_up) begin
			$display("%0t: link_up expected %0b got %0b", $time, exp.link_up, got.link_up);
			mismatches++;
		end
		if (got.start_attempt !== exp.start_attempt) begin
			$display("%0t: start_attempt expected %0b got %0b", $time,
				exp.start_attempt, got.start_attempt);
			mismatches++;
		end
		if (got.reboot_request !== exp.reboot_request) begin
			$display("%0t: reboot_request expected %0b got %0b", $time,
				exp.reboot_request, got.reboot_request);
			mismatches++;
		end
		if (got.backoff_write !== exp.backoff_write) begin
			$display("%0t: backoff_write expected %0b got %0b", $time,
				exp.backoff_write, got.backoff_write);
			mismatches++;
		end
		if (got.backoff_value !== exp.backoff_value) begin
			$display("%0t: backoff_value expected %h got %h", $time,
				exp.backoff_value, got.backoff_value);
			mismatches++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcbs_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	lcbs_poll_if   poll_ch ();
	lcbs_result_if res_ch ();
	lcbs_cfg_if    cfg_ch ();

	link_connect_backoff_supervisor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	backoff_tracker tracker;
	int             src_idle_pct;
	int             sink_idle_pct;
	int             polls_sent;
	int             reports_seen;
	int             hold_left;
	int             settings_run;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("link_connect_backoff_supervisor regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		result_t got;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.link_up        = res_ch.link_up;
			got.start_attempt  = res_ch.start_attempt;
			got.reboot_request = res_ch.reboot_request;
			got.backoff_write  = res_ch.backoff_write;
			got.backoff_value  = res_ch.backoff_value;
			tracker.check_report(got);
			reports_seen++;
			if (reports_seen == 300 || reports_seen == 1000)
				hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_poll(input logic [TIME_W-1:0] now, input logic [STATUS_W-1:0] st);
		if (polls_sent < 450) begin
			src_idle_pct = 10;
			sink_idle_pct = 86;
		end else if (polls_sent < 900) begin
			src_idle_pct = 86;
			sink_idle_pct = 10;
		end else begin
			src_idle_pct = 0;
			sink_idle_pct = 0;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			poll_ch.valid <= 1'b0;
			@(posedge clk);
		end
		poll_ch.valid       <= 1'b1;
		poll_ch.now_ms      <= now;
		poll_ch.link_status <= st;
		do @(posedge clk); while (poll_ch.ready !== 1'b1);
		tracker.note_poll(now, st);
		polls_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		tracker.load_reg(idx, val);
	endtask

	task automatic drain();
		poll_ch.valid <= 1'b0;
		while (tracker.expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [TIME_W-1:0] ci, ri, ib, mb, ct, rb);
		drain();
		write_reg(CFG_CHECK_INTERVAL, ci);
		write_reg(CFG_RETRY_INTERVAL, ri);
		write_reg(CFG_INITIAL_BACKOFF, ib);
		write_reg(CFG_MAXIMUM_BACKOFF, mb);
		write_reg(CFG_CONNECT_TIMEOUT, ct);
		write_reg(CFG_RESTORED_BACKOFF, rb);
		if (settings_run == 0) begin
			write_reg(3'(CFG_RESTORED_BACKOFF + 1), $urandom());
			write_reg(3'(CFG_RESTORED_BACKOFF + 2), $urandom());
		end
		cfg_ch.valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [STATUS_W-1:0] pick_status();
		int w;
		w = $urandom_range(99);
		if (w < 8)
			return ST_CONNECTED;
		else if (w < 20)
			return ST_FAILED;
		else if (w < 28)
			return ST_NO_NET;
		else if (w < 53)
			return ST_IDLE;
		else if (w < 73)
			return ST_DISCONNECTED;
		else if (w < 85) begin
			case ($urandom_range(2))
				0: return ST_SCAN_DONE;
				1: return ST_LOST;
				default: return ST_BAD_KEY;
			endcase
		end else if (w < 98)
			return STATUS_W'(ST_NO_DEVICE) + STATUS_W'($urandom_range(1, 7));
		else
			return ST_NO_DEVICE;
	endfunction

	task automatic run_polls(input int count, input logic [TIME_W-1:0] start_ms,
		input int unsigned max_step);
		logic [TIME_W-1:0] clock_ms;
		logic [TIME_W-1:0] now;
		clock_ms = start_ms;
		repeat (count) begin
			if (clock_ms < tracker.poll_due && tracker.poll_due - clock_ms > 32 * max_step
					&& $urandom_range(3) == 0)
				clock_ms = tracker.poll_due;
			if ($urandom_range(99) < 5) begin
				now = $urandom();
			end else begin
				clock_ms = clock_ms + $urandom_range(max_step);
				now = clock_ms;
			end
			send_poll(now, pick_status());
		end
	endtask

	initial begin
		tracker = new;
		tracker.power_on();
		arst_n              = 1'b0;
		poll_ch.valid       = 1'b0;
		poll_ch.now_ms      = '0;
		poll_ch.link_status = '0;
		res_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		src_idle_pct        = 0;
		sink_idle_pct       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_poll(32'd0, ST_IDLE);
		send_poll(32'd0, ST_FAILED);
		send_poll(32'd100, ST_IDLE);
		send_poll(32'd5000, ST_NO_NET);
		send_poll(32'd5000, ST_NO_NET);
		send_poll(32'd70000, ST_IDLE);
		send_poll(32'd70000, ST_DISCONNECTED);
		send_poll(32'd131000, ST_IDLE);
		send_poll(32'd131000, ST_SCAN_DONE);
		send_poll(32'd131000, ST_LOST);
		send_poll(32'd200000, ST_BAD_KEY);
		send_poll(32'd200000, ST_CONNECTED);
		send_poll(32'd200000, ST_CONNECTED);
		send_poll(32'd300000, STATUS_W'(ST_NO_DEVICE) + STATUS_W'(1));
		send_poll(32'd300000, '1);
		send_poll(32'd400000, ST_NO_DEVICE);
		send_poll(32'd400000, ST_NO_DEVICE);
		send_poll(32'd500000, ST_IDLE);
		send_poll(POLL_NEVER, ST_DISCONNECTED);
		send_poll(POLL_NEVER, ST_FAILED);
		send_poll(32'd4999, ST_IDLE);
		send_poll(32'd4999, ST_FAILED);
		send_poll(POLL_NEVER, ST_CONNECTED);

		apply_setting(32'd5, 32'd20, 32'd50, 32'd400, 32'd100, 32'd0);
		run_polls(300, 32'd1000, 40);
		apply_setting('0, '0, 32'd1, '1, '0, '0);
		run_polls(150, 32'hFFFF_FF00, 8);
		apply_setting('1, '1, '1, 32'd1, '1, '1);
		run_polls(150, $urandom(), 1000);
		repeat (4) begin
			apply_setting($urandom_range(60), $urandom_range(200), $urandom_range(1, 300),
				$urandom_range(1, 3000), $urandom_range(400),
				$urandom_range(1) ? 32'd0 : 32'($urandom_range(1, 500)));
			run_polls(150, $urandom(), $urandom_range(1, 80));
		end
		apply_setting(32'd10, 32'd30, 32'd60, 32'd100, 32'd120, 32'd0);
		run_polls(150, 32'd50, 50);

		drain();
		$display("%0d polls under %0d register settings plus reset values", polls_sent,
			settings_run);
		$display("%0d attempts, %0d link-up reports, %0d reboot requests, %0d backoff writes",
			tracker.attempts, tracker.ups, tracker.reboots, tracker.bo_writes);
		if (tracker.mismatches == 0)
			$display("link_connect_backoff_supervisor regression: pass");
		else
			$display("link_connect_backoff_supervisor regression: fail");
		$finish;
	end
endmodule
